// ===== sv/llfc_pkg.sv =====
// Package for the liquid level fill controller.
// Holds the payload, configuration and code types shared by all modules.
// No dependencies.
package llfc_pkg;

    localparam int LEVEL_W   = 16;
    localparam int BURST_W   = 16;
    localparam int TIMEOUT_W = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_ADDR_W = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_THRESHOLD  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_THRESHOLD = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PUMP_ON_TICKS  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PUMP_OFF_TICKS = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FILL_TIMEOUT   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PUMP_PRESENT   = 3'd5;

    // Event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_START = 2'd1;
    localparam logic [1:0] EV_STOP  = 2'd2;
    localparam logic [1:0] EV_ERROR = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_TEMP_HIGH = 2'd1;
    localparam logic [1:0] ERR_TEMP_LOW  = 2'd2;
    localparam logic [1:0] ERR_TIMEOUT   = 2'd3;

    // Level classes
    localparam logic [1:0] LV_LOW   = 2'd0;
    localparam logic [1:0] LV_RANGE = 2'd1;
    localparam logic [1:0] LV_HIGH  = 2'd2;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_sample;
        logic               temperature_ok;
        logic               over_temp;
        logic               monitor_on;
    } in_item_t;

    typedef struct packed {
        logic       pump_drive;
        logic [1:0] event_kind;
        logic [1:0] error_code;
        logic       standby;
        logic [1:0] level_class;
    } out_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]   low_threshold;
        logic [LEVEL_W-1:0]   high_threshold;
        logic [BURST_W-1:0]   pump_on_ticks;
        logic [BURST_W-1:0]   pump_off_ticks;
        logic [TIMEOUT_W-1:0] fill_timeout_ticks;
        logic                 pump_present;
    } cfg_t;

endpackage

// ===== sv/llfc_core.sv =====
// Fill controller state machine: one tick per step, result registered.
// Depends on llfc_pkg.
module llfc_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  llfc_pkg::in_item_t item,
    input  llfc_pkg::cfg_t    cfg,
    output llfc_pkg::out_item_t result
);
    import llfc_pkg::*;

    typedef enum logic [1:0] {
        PH_CHECK = 2'd0,
        PH_ON    = 2'd1,
        PH_OFF   = 2'd2
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic                 fill_active_reg, fill_active_next;
    logic                 armed_reg, armed_next;
    logic [TIMEOUT_W-1:0] fill_cd_reg, fill_cd_next;
    logic [BURST_W-1:0]   burst_cd_reg, burst_cd_next;
    logic                 fault_reg, fault_next;
    logic [1:0]           last_error_reg, last_error_next;
    logic                 prev_mon_reg;
    out_item_t            result_reg, result_next;

    always_comb begin
        logic       rising;
        logic       stopped;
        logic       go;
        logic [1:0] cls;
        logic [1:0] ev;
        logic       standby;

        if (item.level_sample < cfg.low_threshold) begin
            cls = LV_LOW;
        end else if (item.level_sample > cfg.high_threshold) begin
            cls = LV_HIGH;
        end else begin
            cls = LV_RANGE;
        end

        rising  = item.monitor_on && !prev_mon_reg;
        ev      = EV_NONE;
        standby = 1'b0;
        go      = 1'b0;

        // Rising monitor enable restarts the fill bookkeeping
        fill_active_next = rising ? 1'b0 : fill_active_reg;
        armed_next       = rising ? 1'b0 : armed_reg;
        fault_next       = rising ? 1'b0 : fault_reg;
        last_error_next  = rising ? ERR_NONE : last_error_reg;
        stopped          = !item.monitor_on || fault_next;

        fill_cd_next = fill_cd_reg;
        if (armed_next && fill_cd_reg != '0) begin
            fill_cd_next = fill_cd_reg - TIMEOUT_W'(1);
        end

        phase_next    = phase_reg;
        burst_cd_next = burst_cd_reg;

        case (phase_reg)
            PH_ON: begin
                if (burst_cd_reg != '0) begin
                    burst_cd_next = burst_cd_reg - BURST_W'(1);
                end
                if (burst_cd_next == '0 || cls == LV_HIGH || stopped) begin
                    burst_cd_next = cfg.pump_off_ticks;
                    phase_next    = PH_OFF;
                    ev            = EV_STOP;
                end
            end
            PH_OFF: begin
                if (burst_cd_reg != '0) begin
                    burst_cd_next = burst_cd_reg - BURST_W'(1);
                end
                if (stopped || burst_cd_next == '0) begin
                    phase_next = PH_CHECK;
                end
            end
            default: begin
                phase_next = PH_CHECK;
                if (stopped) begin
                    standby = 1'b1;
                end else if (cfg.pump_present) begin
                    if (!item.temperature_ok) begin
                        last_error_next = item.over_temp ? ERR_TEMP_HIGH : ERR_TEMP_LOW;
                        fault_next = 1'b1;
                        ev         = EV_ERROR;
                    end else if (cls == LV_LOW) begin
                        fill_active_next = 1'b1;
                        if (!armed_next) begin
                            armed_next   = 1'b1;
                            fill_cd_next = cfg.fill_timeout_ticks;
                        end
                        go = 1'b1;
                    end else if (cls == LV_HIGH) begin
                        armed_next       = 1'b0;
                        fill_active_next = 1'b0;
                    end else begin
                        go = fill_active_next;
                    end
                    if (go) begin
                        if (armed_next && fill_cd_next == '0) begin
                            last_error_next = ERR_TIMEOUT;
                            fault_next      = 1'b1;
                            ev              = EV_ERROR;
                        end else begin
                            burst_cd_next = cfg.pump_on_ticks;
                            phase_next    = PH_ON;
                            ev            = EV_START;
                        end
                    end
                end
            end
        endcase

        result_next.pump_drive  = (phase_next == PH_ON);
        result_next.event_kind  = ev;
        result_next.error_code  = last_error_next;
        result_next.standby     = standby;
        result_next.level_class = cls;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_CHECK;
            fill_active_reg <= 1'b0;
            armed_reg       <= 1'b0;
            fill_cd_reg     <= '0;
            burst_cd_reg    <= '0;
            fault_reg       <= 1'b0;
            last_error_reg  <= ERR_NONE;
            prev_mon_reg    <= 1'b0;
        end else if (step) begin
            phase_reg       <= phase_next;
            fill_active_reg <= fill_active_next;
            armed_reg       <= armed_next;
            fill_cd_reg     <= fill_cd_next;
            burst_cd_reg    <= burst_cd_next;
            fault_reg       <= fault_next;
            last_error_reg  <= last_error_next;
            prev_mon_reg    <= item.monitor_on;
        end
        if (step) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

    // A latched fault always carries an error code
    a_fault_has_code: assert property (@(posedge aclk) disable iff (!aresetn)
        fault_reg |-> last_error_reg != ERR_NONE)
        else $error("fault latched without error code");

    // The pump phase never holds while a fault is latched
    a_fault_no_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        step && fault_next |-> phase_next != PH_ON)
        else $error("pump burst while faulted");

endmodule

// ===== sv/liquid_level_fill_controller.sv =====
// Top level of the liquid level fill controller: configuration registers,
// input register and result handshake around llfc_core.
// Depends on llfc_pkg and llfc_core.
//
//  port group          dir  handshake          payload
//  s_valid/s_ready     in   valid/ready        s_data   (in_item_t)
//  m_valid/m_ready     out  valid/ready        m_data   (out_item_t)
//  cfg_we              in   write enable only  cfg_addr, cfg_wdata
//
// One tick per clock while the result is not stalled: a tick is taken into the
// input register, worked by the state update and lands in the result register,
// so a new tick can be taken every cycle unless the output stalls.
// Reset is synchronous on aresetn and clears the state and both valid flags.
// A stalled result holds the input register; both stages fill before s_ready drops.
module liquid_level_fill_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  llfc_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output llfc_pkg::out_item_t               m_data,
    input  logic                              cfg_we,
    input  logic [llfc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [llfc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import llfc_pkg::*;

    cfg_t      cfg_reg;
    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      m_valid_reg;
    logic      advance;
    out_item_t result;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_threshold      <= '0;
            cfg_reg.high_threshold     <= '1;
            cfg_reg.pump_on_ticks      <= '0;
            cfg_reg.pump_off_ticks     <= '0;
            cfg_reg.fill_timeout_ticks <= '1;
            cfg_reg.pump_present       <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_LOW_THRESHOLD:  cfg_reg.low_threshold  <= cfg_wdata[LEVEL_W-1:0];
                REG_HIGH_THRESHOLD: cfg_reg.high_threshold <= cfg_wdata[LEVEL_W-1:0];
                REG_PUMP_ON_TICKS:  cfg_reg.pump_on_ticks  <= cfg_wdata[BURST_W-1:0];
                REG_PUMP_OFF_TICKS: cfg_reg.pump_off_ticks <= cfg_wdata[BURST_W-1:0];
                REG_FILL_TIMEOUT:
                    cfg_reg.fill_timeout_ticks <= cfg_wdata[TIMEOUT_W-1:0];
                REG_PUMP_PRESENT:   cfg_reg.pump_present   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    llfc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_data_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = result;

    a_start_drives: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_kind == EV_START |-> m_data.pump_drive)
        else $error("pump start without drive");

    a_stop_releases: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_kind == EV_STOP |-> !m_data.pump_drive)
        else $error("pump stop with drive on");

    a_error_coded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_kind == EV_ERROR
            |-> m_data.error_code != ERR_NONE && !m_data.pump_drive && !m_data.standby)
        else $error("error event inconsistent");

    a_class_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.level_class <= LV_HIGH)
        else $error("level class out of range");

endmodule
